FILE: rtl/srsw_pkg.sv
package srsw_pkg;

	localparam int MAX_WINDOW_DEF = 64;
	localparam int SEQ_W = 32;
	localparam int LEN_W = 11;
	localparam int WS_W = 7;
	localparam int SLOT_OUT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam logic [WS_W-1:0] WS_RESET = 7'd64;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SEQUENCE = 1'b1;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_ACK = 2'd1,
		FUNC_FIND = 2'd2,
		FUNC_RESTART = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		logic [SEQ_W-1:0] sequence_req;
		logic [LEN_W-1:0] packet_length;
	} in_t;

	typedef struct packed {
		logic found;
		logic [LEN_W-1:0] found_length;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic window_open;
		logic window_empty;
		logic lowest_valid;
		logic [SEQ_W-1:0] lowest_sequence;
		logic [SEQ_W-1:0] bottom_sequence;
		logic [SEQ_W-1:0] next_sequence;
	} out_t;

	typedef struct packed {
		logic cap;
		logic mod_req;
		logic mod_scan;
		logic slot_ld;
		logic apply;
		logic find_chk;
		logic scan_rd;
		logic scan_eval;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic last_slot;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/srsw_mod.sv
// sequence mod window size, four quotient bits per cycle
module srsw_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [srsw_pkg::SEQ_W-1:0]    dividend,
	input  logic [srsw_pkg::WS_W-1:0]     divisor,
	output logic                          done,
	output logic [srsw_pkg::WS_W-1:0]     rem
);

	logic [srsw_pkg::SEQ_W-1:0] num_q;
	logic [srsw_pkg::WS_W-1:0] rem_q;
	logic [2:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [srsw_pkg::WS_W-1:0] rem_nx;

	always_comb begin
		logic [srsw_pkg::WS_W:0] t;
		logic [srsw_pkg::WS_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < 4; k++) begin
			t = {r, num_q[srsw_pkg::SEQ_W-1-k]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[srsw_pkg::WS_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 4;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem = rem_q;

endmodule

FILE: rtl/srsw_ctrl.sv
module srsw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  srsw_pkg::stat_t    stat,
	output srsw_pkg::cmd_t     cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_RSTART = 10'b0000000010,
		ST_RWAIT  = 10'b0000000100,
		ST_APPLY  = 10'b0000001000,
		ST_CHECK  = 10'b0000010000,
		ST_RD     = 10'b0000100000,
		ST_MSTART = 10'b0001000000,
		ST_MWAIT  = 10'b0010000000,
		ST_EVAL   = 10'b0100000000,
		ST_FIN    = 10'b1000000000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_nx = ST_RSTART;
				end
			end
			ST_RSTART: begin
				cmd.mod_req = 1'b1;
				state_nx = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (stat.mod_done) begin
					cmd.slot_ld = 1'b1;
					state_nx = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.find_chk = 1'b1;
				state_nx = ST_RD;
			end
			ST_RD: begin
				cmd.scan_rd = 1'b1;
				state_nx = ST_MSTART;
			end
			ST_MSTART: begin
				cmd.mod_scan = 1'b1;
				state_nx = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (stat.mod_done) state_nx = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.scan_eval = 1'b1;
				state_nx = stat.last_slot ? ST_FIN : ST_RD;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

endmodule

FILE: rtl/srsw_dp.sv
module srsw_dp #(
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srsw_pkg::cmd_t                    cmd,
	output srsw_pkg::stat_t                   stat,
	input  srsw_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output srsw_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srsw_pkg::SEQ_W-1:0]        cfg_data
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [srsw_pkg::SEQ_W-1:0] seq_mem [MAX_WINDOW];
	logic [srsw_pkg::LEN_W-1:0] len_mem [MAX_WINDOW];
	logic [srsw_pkg::SEQ_W-1:0] rd_seq_q;
	logic [srsw_pkg::LEN_W-1:0] rd_len_q;
	logic [MAX_WINDOW-1:0] used_q;

	srsw_pkg::func_t func_q;
	logic [srsw_pkg::SEQ_W-1:0] seq_q;
	logic [srsw_pkg::LEN_W-1:0] len_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] idx_q;
	logic [srsw_pkg::SEQ_W-1:0] bottom_q, next_q, limit_q, start_q, low_q;
	logic low_hit_q;
	logic found_q;
	logic [srsw_pkg::LEN_W-1:0] flen_q;
	logic [srsw_pkg::WS_W-1:0] ws_q;
	logic out_valid_q;
	srsw_pkg::out_t out_q;

	logic [srsw_pkg::WS_W-1:0] n_eff;
	logic mod_start, mod_done;
	logic [srsw_pkg::SEQ_W-1:0] mod_arg;
	logic [srsw_pkg::WS_W-1:0] mod_rem;
	logic [IDX_W-1:0] rd_addr;
	logic placed, in_lo, clr, cand;
	logic [srsw_pkg::SEQ_W-1:0] bot_new;
	logic win_open;

	// out-of-range sizes clamp to 1..MAX_WINDOW
	always_comb begin
		if (ws_q == '0) n_eff = srsw_pkg::WS_W'(1);
		else if (32'(ws_q) > MAX_WINDOW) n_eff = srsw_pkg::WS_W'(MAX_WINDOW);
		else n_eff = ws_q;
	end

	assign mod_start = cmd.mod_req | cmd.mod_scan;
	assign mod_arg = cmd.mod_scan ? rd_seq_q : seq_q;

	srsw_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_arg),
		.divisor  (n_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign rd_addr = cmd.scan_rd ? idx_q : slot_q;

	always_ff @(posedge clk) begin
		if (cmd.apply && func_q == srsw_pkg::FUNC_ADD) begin
			seq_mem[slot_q] <= seq_q;
			len_mem[slot_q] <= len_q;
		end
		if (cmd.scan_rd || cmd.apply) begin
			rd_seq_q <= seq_mem[rd_addr];
			rd_len_q <= len_mem[rd_addr];
		end
	end

	// slot check on the word just read
	assign placed = (32'(mod_rem) == 32'(idx_q));
	assign in_lo = (rd_seq_q >= bottom_q);
	assign clr = (func_q == srsw_pkg::FUNC_ACK) && placed && in_lo && (rd_seq_q < limit_q);
	assign cand = used_q[idx_q] && !clr && placed && in_lo && (rd_seq_q < next_q);

	always_comb begin
		bot_new = bottom_q;
		if (func_q == srsw_pkg::FUNC_ACK) begin
			if (low_hit_q) bot_new = low_q;
			else if (bottom_q < next_q) bot_new = next_q;
		end
	end

	assign win_open = ({1'b0, next_q} < ({1'b0, bot_new} + 33'(n_eff)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= srsw_pkg::WS_RESET;
			start_q <= '0;
			bottom_q <= '0;
			next_q <= '0;
			used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					srsw_pkg::REG_WINDOW_SIZE: ws_q <= cfg_data[srsw_pkg::WS_W-1:0];
					srsw_pkg::REG_START_SEQUENCE: start_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.apply) begin
				case (func_q)
					srsw_pkg::FUNC_ADD: begin
						used_q[slot_q] <= 1'b1;
						if (seq_q == next_q) next_q <= next_q + 32'd1;
					end
					srsw_pkg::FUNC_RESTART: begin
						used_q <= '0;
						bottom_q <= start_q;
						next_q <= start_q;
					end
					default: ;
				endcase
			end
			if (cmd.scan_eval && clr) used_q[idx_q] <= 1'b0;
			if (cmd.finish) begin
				bottom_q <= bot_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= in_data.func;
			seq_q <= in_data.sequence_req;
			len_q <= in_data.packet_length;
		end
		if (cmd.slot_ld) slot_q <= IDX_W'(mod_rem);
		if (cmd.apply) limit_q <= (seq_q < next_q) ? seq_q : next_q;
		if (cmd.find_chk) begin
			idx_q <= '0;
			low_hit_q <= 1'b0;
			low_q <= '0;
			found_q <= (func_q == srsw_pkg::FUNC_FIND) && used_q[slot_q] && (rd_seq_q == seq_q);
			flen_q <= rd_len_q;
		end
		if (cmd.scan_eval) begin
			idx_q <= idx_q + IDX_W'(1);
			if (cand && (!low_hit_q || rd_seq_q < low_q)) begin
				low_q <= rd_seq_q;
				low_hit_q <= 1'b1;
			end
		end
		if (cmd.finish) begin
			out_q.found <= found_q;
			out_q.found_length <= found_q ? flen_q : '0;
			out_q.slot_index <= srsw_pkg::SLOT_OUT_W'(slot_q);
			out_q.window_open <= win_open;
			out_q.window_empty <= (bot_new == next_q);
			out_q.lowest_valid <= low_hit_q;
			out_q.lowest_sequence <= low_hit_q ? low_q : '0;
			out_q.bottom_sequence <= bot_new;
			out_q.next_sequence <= next_q;
		end
	end

	assign stat.mod_done = mod_done;
	assign stat.last_slot = (32'(idx_q) == 32'(n_eff) - 32'd1);
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: rtl/selective_repeat_send_window.sv
// Selective-repeat sender window: sequence bookkeeping for an ARQ sender.
// Input channel (in_valid/in_ready/in_data) takes one word per operation:
// add a sent packet, receive-ready ack, find, or restart. Each operation
// returns exactly one result word on out_valid/out_ready/out_data with the
// find result, the slot (sequence mod window size) and the window status.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is window size, index 1 is the restart sequence. Write it idle.
// For window size N (clamped 1..MAX_WINDOW), the slot of the request is
// first found by a modulo of its sequence, then every operation walks all
// N slots once, each by table read, modulo start, 4-bit-per-cycle modulo
// by N and evaluate. A new word is taken only once the previous operation
// has loaded its result into the output register.
// The result sits in an output register: while the receiver stalls the
// block takes and works the next word, then holds in its final cycle.
// Reset: window empty at sequence 0, all slots unused, window size 64.
// Slot contents are stored in on-chip tables; payload bytes live outside,
// addressed by slot_index.
module selective_repeat_send_window #(
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  srsw_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output srsw_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srsw_pkg::SEQ_W-1:0]        cfg_data
);

	srsw_pkg::cmd_t cmd;
	srsw_pkg::stat_t stat;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srsw_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: rtl/srsw_chk.sv
module srsw_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  srsw_pkg::out_t                    out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_empty_no_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.window_empty |-> !out_data.lowest_valid)
		else $error("empty window reports a pending sequence");

	a_low_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.lowest_valid |->
		out_data.lowest_sequence >= out_data.bottom_sequence &&
		out_data.lowest_sequence < out_data.next_sequence)
		else $error("lowest sequence outside window");

	a_miss_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.found_length == '0)
		else $error("length on a find miss");

endmodule

bind selective_repeat_send_window srsw_chk u_chk (.*);
